[rtl/core/spv_pkg.sv]
// ----------------------------------------------------------------------------
// spv_pkg
// Shared types and constants for the one-voice sample player.
// ----------------------------------------------------------------------------
package spv_pkg;

  // Request codes carried on req_type
  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_NOTE_ON  = 2'd1,
    REQ_NOTE_OFF = 2'd2,
    REQ_WRITE    = 2'd3
  } req_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START    = 3'd0,
    CFG_END      = 3'd1,
    CFG_RATE     = 3'd2,
    CFG_REVERSE  = 3'd3,
    CFG_LOOP     = 3'd4,
    CFG_STOP_REL = 3'd5
  } cfg_idx_t;

  // Fixed field widths
  localparam int SAMPLE_W      = 16;
  localparam int MIX_W         = 24;
  localparam int CHAN_W        = 4;
  localparam int RATE_INT_BITS = 4;

  // Saturation limits of the 24-bit mix bus
  localparam logic [MIX_W-1:0] MIX_MAX = {1'b0, {(MIX_W-1){1'b1}}};
  localparam logic [MIX_W-1:0] MIX_MIN = {1'b1, {(MIX_W-1){1'b0}}};

endpackage

[rtl/core/sample_playback_voice.sv]
// ----------------------------------------------------------------------------
// sample_playback_voice
// One-voice sample player: sample writes fill the store, note events start
// and stop playback, audio ticks add the current sample into the mix.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            beat contents
//   in        to block   in_valid / in_stall  req_type channel mix_in
//                                             write_addr write_data
//   out       from block out_valid/out_stall  mix_out playing
//   cfg       to block   cfg_write            cfg_index cfg_data
//
// One beat per clock sustained while out_stall stays low. Voice state (position,
// active, held) is updated in the accept cycle; the sample store read is issued
// at accept and its data comes back in the next cycle, where the add and
// saturate feed the output register. The beat then passes from the read stage
// to the output register, where out_valid is registered and rises.
// Reset clears control and config; the sample store is not cleared.
// in_stall rises only when both the read stage and the output register are
// full and out_stall is high.
// ----------------------------------------------------------------------------
module sample_playback_voice #(
  parameter int ADDR_BITS = 20,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [spv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [((ADDR_BITS+1 > FRAC_BITS+spv_pkg::RATE_INT_BITS) ?
                 ADDR_BITS+1 : FRAC_BITS+spv_pkg::RATE_INT_BITS)-1:0] cfg_data,
  // input beats
  input  logic                                in_valid,
  output logic                                in_stall,
  input  spv_pkg::req_t                       req_type,
  input  logic [spv_pkg::CHAN_W-1:0]          channel,
  input  logic signed [spv_pkg::MIX_W-1:0]    mix_in,
  input  logic [ADDR_BITS-1:0]                write_addr,
  input  logic signed [spv_pkg::SAMPLE_W-1:0] write_data,
  // output beats
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [spv_pkg::MIX_W-1:0]    mix_out,
  output logic                                playing
);
  import spv_pkg::*;

  localparam int IDX_W  = ADDR_BITS + 1;
  localparam int POS_W  = IDX_W + FRAC_BITS;
  localparam int RATE_W = FRAC_BITS + RATE_INT_BITS;

  // configuration registers
  logic [ADDR_BITS-1:0] start_point;
  logic [IDX_W-1:0]     end_point;
  logic [RATE_W-1:0]    step_rate;
  logic                 reverse_dir;
  logic                 loop_mode;
  logic                 stop_on_release;

  // voice state
  logic [POS_W-1:0] play_position, play_position_next;
  logic             voice_active, voice_active_next;
  logic             note_held, note_held_next;

  // read stage
  logic             s1_valid;
  logic [MIX_W-1:0] s1_mix;
  logic             s1_hit;
  logic             s1_playing;
  logic             s1_adv;

  // store interface
  logic                 mem_wr;
  logic                 rd_en;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [SAMPLE_W-1:0]  rd_data;

  logic             in_fire;
  logic             ch0;
  logic [IDX_W-1:0] win_len;
  logic [IDX_W-1:0] pos_idx;
  logic [POS_W-1:0] rate_pos;
  logic [POS_W-1:0] fwd_pos;
  logic [POS_W-1:0] last_pos;
  logic             wrap;
  logic             play_hit;
  logic [MIX_W:0]   mix_sum;
  logic [MIX_W-1:0] mix_sel;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_point     <= '0;
      end_point       <= '0;
      step_rate       <= RATE_W'(1) << FRAC_BITS;
      reverse_dir     <= 1'b0;
      loop_mode       <= 1'b0;
      stop_on_release <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START:    start_point     <= cfg_data[ADDR_BITS-1:0];
        CFG_END:      end_point       <= cfg_data[IDX_W-1:0];
        CFG_RATE:     step_rate       <= cfg_data[RATE_W-1:0];
        CFG_REVERSE:  reverse_dir     <= cfg_data[0];
        CFG_LOOP:     loop_mode       <= cfg_data[0];
        CFG_STOP_REL: stop_on_release <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_fire  = in_valid && !in_stall;
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  // window and position arithmetic
  assign ch0      = (channel == '0);
  assign win_len  = (end_point > IDX_W'(start_point)) ?
                    end_point - IDX_W'(start_point) : '0;
  assign pos_idx  = play_position[POS_W-1:FRAC_BITS];
  assign rate_pos = POS_W'(step_rate);
  assign fwd_pos  = play_position + rate_pos;
  assign last_pos = {win_len - IDX_W'(1), {FRAC_BITS{1'b0}}};
  assign wrap     = loop_mode && note_held;
  assign rd_addr  = start_point + pos_idx[ADDR_BITS-1:0];

  // voice next state
  always_comb begin
    play_position_next = play_position;
    voice_active_next  = voice_active;
    note_held_next     = note_held;
    play_hit           = 1'b0;
    case (req_type)
      REQ_NOTE_ON: begin
        if (ch0) begin
          note_held_next = 1'b1;
          if (win_len != '0) begin
            play_position_next = reverse_dir ? last_pos : '0;
            voice_active_next  = 1'b1;
          end else begin
            voice_active_next = 1'b0;
          end
        end
      end
      REQ_NOTE_OFF: begin
        if (ch0) begin
          note_held_next = 1'b0;
          if (stop_on_release) begin
            voice_active_next = 1'b0;
          end
        end
      end
      REQ_TICK: begin
        if (voice_active && step_rate != '0) begin
          if (pos_idx >= win_len) begin
            // window shrank under the voice
            voice_active_next = 1'b0;
          end else begin
            play_hit = 1'b1;
            if (!reverse_dir) begin
              play_position_next = fwd_pos;
              if (fwd_pos[POS_W-1:FRAC_BITS] >= win_len) begin
                if (wrap) play_position_next = '0;
                else      voice_active_next  = 1'b0;
              end
            end else if (play_position < rate_pos) begin
              if (wrap) play_position_next = last_pos;
              else      voice_active_next  = 1'b0;
            end else begin
              play_position_next = play_position - rate_pos;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign rd_en  = in_fire && play_hit;
  assign mem_wr = in_fire && (req_type == REQ_WRITE);

  // voice state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      play_position <= '0;
      voice_active  <= 1'b0;
      note_held     <= 1'b0;
    end else if (in_fire) begin
      play_position <= play_position_next;
      voice_active  <= voice_active_next;
      note_held     <= note_held_next;
    end
  end

  spv_sample_ram #(
    .ADDR_BITS (ADDR_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (write_addr),
    .wr_data (write_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // read stage: waits for the store data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mix     <= mix_in;
      s1_hit     <= play_hit;
      s1_playing <= voice_active_next;
    end
  end

  // add and saturate
  assign mix_sum = {s1_mix[MIX_W-1], s1_mix} +
                   {{(MIX_W+1-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};

  always_comb begin
    mix_sel = s1_mix;
    if (s1_hit) begin
      if (mix_sum[MIX_W] != mix_sum[MIX_W-1]) begin
        mix_sel = mix_sum[MIX_W] ? MIX_MIN : MIX_MAX;
      end else begin
        mix_sel = mix_sum[MIX_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mix_out <= mix_sel;
      playing <= s1_playing;
    end
  end

  // checks
  a_start_by_note_on: assert property (@(posedge clk) disable iff (rst)
    $rose(voice_active) |->
      $past(in_fire && req_type == REQ_NOTE_ON && channel == '0))
    else $error("voice started without a note-on on channel 0");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  a_read_on_tick: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (req_type == REQ_TICK && voice_active))
    else $error("store read outside an active tick");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_mix)))
    else $error("read stage lost a held beat");

endmodule

[rtl/core/spv_sample_ram.sv]
// ----------------------------------------------------------------------------
// spv_sample_ram
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spv_sample_ram #(
  parameter int ADDR_BITS = 20
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_BITS-1:0]         wr_addr,
  input  logic [spv_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_BITS-1:0]         rd_addr,
  output logic [spv_pkg::SAMPLE_W-1:0] rd_data
);
  import spv_pkg::*;

  logic [SAMPLE_W-1:0] mem [0:(1 << ADDR_BITS)-1];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sim/tb_sample_playback_voice.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_playback_voice
// Self-checking bench for the one-voice sample player. A directed table
// covers reset state, empty windows, saturation, other channels, zero rate,
// the top-of-store window, loop wrap both ways, release stop and a shrunk
// window. Then random phases: each one reprograms the window and playback
// mode while idle and sends note, tick and write beats. Every output beat is
// checked against the table on checked rows, else against an in-bench voice
// predictor, with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb_sample_playback_voice;
  import spv_pkg::*;

  localparam int ADDR_BITS = 20;
  localparam int FRAC_BITS = 16;
  localparam int CFG_W = (ADDR_BITS + 1 > FRAC_BITS + RATE_INT_BITS) ?
                         ADDR_BITS + 1 : FRAC_BITS + RATE_INT_BITS;
  localparam longint unsigned STORE_WORDS = longint'(1) << ADDR_BITS;
  localparam logic [CHAN_W-1:0] VOICE_CHAN = '0;
  // indexes past the register file; the block must ignore them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int SAT_HI = 8388607;
  localparam int SAT_LO = -8388608;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 22;
  localparam int PHASE_BEATS = 80;
  localparam int CALM_BEATS = 240;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix;
    logic                    play;
  } voice_out_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // arg is the write address on item rows and the register value on reg rows
  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] ridx;
    req_t                 rq;
    logic [CHAN_W-1:0]    ch;
    int                   mix;
    logic [CFG_W-1:0]     arg;
    int                   wd;
    bit                   chk;
    int                   e_mix;
    bit                   e_play;
  } dir_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = CFG_START;
  logic [CFG_W-1:0]            cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  req_t                        req_type = REQ_TICK;
  logic [CHAN_W-1:0]           channel = '0;
  logic signed [MIX_W-1:0]     mix_in = '0;
  logic [ADDR_BITS-1:0]        write_addr = '0;
  logic signed [SAMPLE_W-1:0]  write_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [MIX_W-1:0]     mix_out;
  logic                        playing;

  // voice predictor state
  logic signed [SAMPLE_W-1:0]  sample_store [longint unsigned];
  longint unsigned             voice_pos = 0;
  bit                          voice_on = 0;
  bit                          key_down = 0;
  logic [ADDR_BITS-1:0]        reg_start = '0;
  logic [ADDR_BITS:0]          reg_end = '0;
  logic [FRAC_BITS+3:0]        reg_rate = (FRAC_BITS+4)'(1) << FRAC_BITS;
  bit                          reg_rev = 0;
  bit                          reg_loop = 0;
  bit                          reg_stop = 0;

  voice_out_t                  due_mix_q [$];
  int                          n_bad = 0;
  int                          cycle_cnt = 0;
  int                          stall_left = 0;
  bit                          calm = 0;
  bit                          in_quiet = 0;
  bit                          out_quiet = 0;

  dir_row_t dir_plan [39] = '{
    // reset state, empty window, sample loads at the field extremes
    '{ROW_ITEM, CFG_START, REQ_TICK,     4'd0,  0,        21'd0,       0,      1, 0, 0},
    '{ROW_ITEM, CFG_START, REQ_NOTE_ON,  4'd0,  123,      21'd0,       0,      1, 123, 0},
    '{ROW_ITEM, CFG_START, REQ_WRITE,    4'd0,  -8388608, 21'd0,       32767,  1, -8388608, 0},
    '{ROW_ITEM, CFG_START, REQ_WRITE,    4'd0,  8388607,  21'd1,       -32768, 1, 8388607, 0},
    '{ROW_ITEM, CFG_START, REQ_WRITE,    4'd0,  0,        21'd2,       0,      1, 0, 0},
    '{ROW_ITEM, CFG_START, REQ_WRITE,    4'd0,  0,        21'hFFFFF,   4660,   1, 0, 0},
    // three-sample window, forward at unit rate, saturation both ways
    '{ROW_REG,  CFG_END,   REQ_TICK,     4'd0,  0,        21'd3,       0,      0, 0, 0},
    '{ROW_ITEM, CFG_START, REQ_NOTE_ON,  4'd15, 5,        21'd0,       0,      1, 5, 0},
    '{ROW_ITEM, CFG_START, REQ_NOTE_ON,  4'd0,  7,        21'd0,       0,      1, 7, 1},
    '{ROW_ITEM, CFG_START, REQ_TICK,     4'd0,  8388607,  21'd0,       0,      1, 8388607, 1},
    '{ROW_ITEM, CFG_START, REQ_TICK,     4'd0,  -8388608, 21'd0,       0,      1, -8388608, 1},
    '{ROW_ITEM, CFG_START, REQ_TICK,     4'd0,  10,       21'd0,       0,      1, 10, 0},
    // zero rate: tick passes the mix through, voice stays on
    '{ROW_REG,  CFG_RATE,  REQ_TICK,     4'd0,  0,        21'd0,       0,      0, 0, 0},
    '{ROW_ITEM, CFG_START, REQ_NOTE_ON,  4'd0,  0,        21'd0,       0,      1, 0, 1},
    '{ROW_ITEM, CFG_START, REQ_TICK,     4'd0,  20,       21'd0,       0,      1, 20, 1},
    // last word of the store, max rate, loop while held
    '{ROW_REG,  CFG_START, REQ_TICK,     4'd0,  0,        21'hFFFFF,   0,      0, 0, 0},
    '{ROW_REG,  CFG_END,   REQ_TICK,     4'd0,  0,        21'h100000,  0,      0, 0, 0},
    '{ROW_REG,  CFG_RATE,  REQ_TICK,     4'd0,  0,        21'hFFFFF,   0,      0, 0, 0},
    '{ROW_REG,  CFG_LOOP,  REQ_TICK,     4'd0,  0,        21'd1,       0,      0, 0, 0},
    '{ROW_REG,  CFG_SPARE_A, REQ_TICK,   4'd0,  0,        21'd0,       0,      0, 0, 0},
    '{ROW_REG,  CFG_SPARE_B, REQ_TICK,   4'd0,  0,        21'h1FFFFF,  0,      0, 0, 0},
    '{ROW_ITEM, CFG_START, REQ_NOTE_ON,  4'd0,  0,        21'd0,       0,      1, 0, 1},
    '{ROW_ITEM, CFG_START, REQ_TICK,     4'd0,  0,        21'd0,       0,      1, 4660, 1},
    '{ROW_ITEM, CFG_START, REQ_NOTE_OFF, 4'd0,  1,        21'd0,       0,      1, 1, 1},
    '{ROW_ITEM, CFG_START, REQ_TICK,     4'd0,  0,        21'd0,       0,      1, 4660, 0},
    // reverse with loop and stop on release
    '{ROW_REG,  CFG_STOP_REL, REQ_TICK,  4'd0,  0,        21'd1,       0,      0, 0, 0},
    '{ROW_REG,  CFG_REVERSE, REQ_TICK,   4'd0,  0,        21'd1,       0,      0, 0, 0},
    '{ROW_REG,  CFG_START, REQ_TICK,     4'd0,  0,        21'd0,       0,      0, 0, 0},
    '{ROW_REG,  CFG_END,   REQ_TICK,     4'd0,  0,        21'd3,       0,      0, 0, 0},
    '{ROW_REG,  CFG_RATE,  REQ_TICK,     4'd0,  0,        21'h10000,   0,      0, 0, 0},
    '{ROW_ITEM, CFG_START, REQ_NOTE_ON,  4'd0,  -1,       21'd0,       0,      1, -1, 1},
    '{ROW_ITEM, CFG_START, REQ_TICK,     4'd0,  100,      21'd0,       0,      0, 0, 0},
    '{ROW_ITEM, CFG_START, REQ_TICK,     4'd0,  100,      21'd0,       0,      0, 0, 0},
    '{ROW_ITEM, CFG_START, REQ_TICK,     4'd0,  0,        21'd0,       0,      0, 0, 0},
    '{ROW_ITEM, CFG_START, REQ_NOTE_OFF, 4'd3,  0,        21'd0,       0,      1, 0, 1},
    '{ROW_ITEM, CFG_START, REQ_NOTE_OFF, 4'd0,  0,        21'd0,       0,      1, 0, 0},
    '{ROW_ITEM, CFG_START, REQ_NOTE_ON,  4'd0,  0,        21'd0,       0,      1, 0, 1},
    // window shrinks under a running voice
    '{ROW_REG,  CFG_END,   REQ_TICK,     4'd0,  0,        21'd1,       0,      0, 0, 0},
    '{ROW_ITEM, CFG_START, REQ_TICK,     4'd0,  55,       21'd0,       0,      1, 55, 0}
  };

  sample_playback_voice #(
    .ADDR_BITS(ADDR_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .channel   (channel),
    .mix_in    (mix_in),
    .write_addr(write_addr),
    .write_data(write_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mix_out   (mix_out),
    .playing   (playing)
  );

  always #1 clk = ~clk;

  // window length, zero when end is not past start
  function automatic longint unsigned window_length();
    return (reg_end > reg_start) ? longint'(reg_end) - longint'(reg_start) : 0;
  endfunction

  // advance the voice by one input beat and return the beat it must emit
  function automatic voice_out_t voice_predict(req_t rq, logic [CHAN_W-1:0] ch,
                                               logic signed [MIX_W-1:0] mx,
                                               logic [ADDR_BITS-1:0] wa,
                                               logic signed [SAMPLE_W-1:0] wd);
    voice_out_t r;
    longint unsigned wlen;
    longint unsigned idx;
    longint unsigned ra;
    int sum;
    bit wrap;
    wlen = window_length();
    r.mix = mx;
    case (rq)
      REQ_WRITE: sample_store[longint'(wa)] = wd;
      REQ_NOTE_ON: begin
        if (ch == VOICE_CHAN) begin
          key_down = 1;
          if (wlen > 0) begin
            voice_pos = reg_rev ? (wlen - 1) << FRAC_BITS : 0;
            voice_on = 1;
          end else begin
            voice_on = 0;
          end
        end
      end
      REQ_NOTE_OFF: begin
        if (ch == VOICE_CHAN) begin
          key_down = 0;
          if (reg_stop) voice_on = 0;
        end
      end
      default: begin
        if (voice_on && reg_rate != 0) begin
          idx = voice_pos >> FRAC_BITS;
          if (idx >= wlen) begin
            voice_on = 0;
          end else begin
            ra = (longint'(reg_start) + idx) % STORE_WORDS;
            sum = int'(mx) + int'(sample_store[ra]);
            if (sum > SAT_HI) sum = SAT_HI;
            if (sum < SAT_LO) sum = SAT_LO;
            r.mix = sum[MIX_W-1:0];
            wrap = reg_loop && key_down;
            if (!reg_rev) begin
              voice_pos += reg_rate;
              if ((voice_pos >> FRAC_BITS) >= wlen) begin
                if (wrap) voice_pos = 0;
                else voice_on = 0;
              end
            end else if (voice_pos < reg_rate) begin
              if (wrap) voice_pos = (wlen - 1) << FRAC_BITS;
              else voice_on = 0;
            end else begin
              voice_pos -= reg_rate;
            end
          end
        end
      end
    endcase
    r.play = voice_on;
    return r;
  endfunction

  // one register write; caller lowers cfg_write after the last of a batch
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_START:    reg_start = val[ADDR_BITS-1:0];
      CFG_END:      reg_end = val[ADDR_BITS:0];
      CFG_RATE:     reg_rate = val[FRAC_BITS+3:0];
      CFG_REVERSE:  reg_rev = val[0];
      CFG_LOOP:     reg_loop = val[0];
      CFG_STOP_REL: reg_stop = val[0];
      default: ;
    endcase
  endtask

  // drain: no beat in flight, then a short pause past the block's latency
  task automatic settle();
    in_valid <= 1'b0;
    while (due_mix_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // hold one input beat until accepted, then log its expected output beat
  task automatic send_item(req_t rq, logic [CHAN_W-1:0] ch, logic signed [MIX_W-1:0] mx,
                           logic [ADDR_BITS-1:0] wa, logic signed [SAMPLE_W-1:0] wd,
                           bit typed, logic signed [MIX_W-1:0] t_mix, bit t_play);
    voice_out_t got;
    bit taken;
    req_type   <= rq;
    channel    <= ch;
    mix_in     <= mx;
    write_addr <= wa;
    write_data <= wd;
    in_valid   <= 1'b1;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = in_valid && !in_stall;
      @(posedge clk);
    end
    got = voice_predict(rq, ch, mx, wa, wd);
    if (typed) begin
      got.mix  = t_mix;
      got.play = t_play;
    end
    due_mix_q.push_back(got);
    if (!calm && !in_quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // mostly ticks on a held note, with note events and writes mixed in
  task automatic random_item();
    req_t rq;
    logic [CHAN_W-1:0] ch;
    logic signed [MIX_W-1:0] mx;
    logic [ADDR_BITS-1:0] wa;
    logic signed [SAMPLE_W-1:0] wd;
    longint unsigned wlen;
    longint unsigned idx;
    logic [ADDR_BITS-1:0] ra;
    int pick;
    pick = $urandom_range(0, 99);
    ch = ($urandom_range(0, 4) == 0) ? CHAN_W'($urandom_range(1, 15)) : VOICE_CHAN;
    if ($urandom_range(0, 9) == 0) mx = $urandom_range(0, 1) ? MIX_MAX : MIX_MIN;
    else mx = MIX_W'($urandom);
    wd = SAMPLE_W'($urandom);
    wa = ADDR_BITS'($urandom);
    wlen = window_length();
    idx = voice_pos >> FRAC_BITS;
    if (pick < 8) begin
      rq = REQ_NOTE_ON;
    end else if (pick < 13) begin
      rq = REQ_NOTE_OFF;
    end else if (pick < 35) begin
      rq = REQ_WRITE;
      // most writes land just ahead of the play point inside the window
      if (pick < 28 && wlen > 0)
        wa = ADDR_BITS'(longint'(reg_start) + (voice_on ? idx : 0) +
                        $urandom_range(0, 15));
    end else begin
      rq = REQ_TICK;
    end
    // a tick must never read a word that was never loaded
    if (rq == REQ_TICK && voice_on && reg_rate != 0 && idx < wlen) begin
      ra = ADDR_BITS'(longint'(reg_start) + idx);
      if (!sample_store.exists(longint'(ra)))
        send_item(REQ_WRITE, ch, mx, ra, SAMPLE_W'($urandom), 0, '0, 0);
    end
    send_item(rq, ch, mx, wa, wd, 0, '0, 0);
  endtask

  // random window and playback mode, written while the block is idle
  task automatic program_voice(bit spare);
    logic [ADDR_BITS-1:0] st;
    logic [ADDR_BITS:0] en;
    logic [FRAC_BITS+3:0] rt;
    longint unsigned span;
    int pick;
    span = $urandom_range(1, 64);
    st = ADDR_BITS'($urandom);
    case ($urandom_range(0, 9))
      0: en = $urandom_range(0, 1) ? {1'b0, st} : '0;
      1: begin
        st = ADDR_BITS'(STORE_WORDS - span);
        en = (ADDR_BITS+1)'(STORE_WORDS);
      end
      2: begin
        st = '0;
        en = (ADDR_BITS+1)'(span);
      end
      3: en = (ADDR_BITS+1)'(STORE_WORDS);
      default: begin
        en = (ADDR_BITS+1)'(longint'(st) + span);
        if (longint'(en) > STORE_WORDS || en < st) en = (ADDR_BITS+1)'(STORE_WORDS);
      end
    endcase
    pick = $urandom_range(0, 15);
    if (pick == 0) rt = '0;
    else if (pick == 1) rt = '1;
    else if (pick == 2) rt = (FRAC_BITS+4)'($urandom);
    else if (pick < 7) rt = (FRAC_BITS+4)'(1) << FRAC_BITS;
    else rt = (FRAC_BITS+4)'($urandom_range(32'h1000, 32'h28000));
    set_reg(CFG_START, CFG_W'(st));
    set_reg(CFG_END, CFG_W'(en));
    set_reg(CFG_RATE, CFG_W'(rt));
    set_reg(CFG_REVERSE, CFG_W'($urandom_range(0, 1)));
    set_reg(CFG_LOOP, CFG_W'($urandom_range(0, 1)));
    set_reg(CFG_STOP_REL, CFG_W'($urandom_range(0, 1)));
    if (spare) set_reg(CFG_SPARE_B, CFG_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  // output-side stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!rst && !calm && !out_quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output beat checker; values are settled by the falling edge
  always @(negedge clk) begin
    voice_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (due_mix_q.size() == 0) begin
        $error("unexpected beat: mix_out=%0d playing=%0d", mix_out, playing);
        n_bad++;
      end else begin
        e = due_mix_q.pop_front();
        if (mix_out !== e.mix) begin
          $error("mix_out: expected %0d, got %0d", e.mix, mix_out);
          n_bad++;
        end
        if (playing !== e.play) begin
          $error("playing: expected %0d, got %0d", e.play, playing);
          n_bad++;
        end
      end
    end
  end

  initial begin
    bit reg_mode;
    reg_mode = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table; register rows wait for the block to drain
    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == ROW_REG) begin
        if (!reg_mode) begin
          settle();
          reg_mode = 1;
        end
        set_reg(dir_plan[i].ridx, dir_plan[i].arg);
      end else begin
        if (reg_mode) begin
          cfg_write <= 1'b0;
          reg_mode = 0;
        end
        send_item(dir_plan[i].rq, dir_plan[i].ch, dir_plan[i].mix[MIX_W-1:0],
                  dir_plan[i].arg[ADDR_BITS-1:0], dir_plan[i].wd[SAMPLE_W-1:0],
                  dir_plan[i].chk, dir_plan[i].e_mix[MIX_W-1:0], dir_plan[i].e_play);
      end
    end

    // random phases, each with its own settings and idling mix
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      program_voice(ph % 5 == 0);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      repeat (PHASE_BEATS) random_item();
    end

    // closing stretch at full rate
    settle();
    program_voice(0);
    calm = 1;
    repeat (CALM_BEATS) random_item();

    in_valid <= 1'b0;
    while (due_mix_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_bad == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
